>>> src/afbb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package afbb_pkg;

    localparam int COORD_W = 32;
    localparam int SIZE_W  = 31;
    localparam int CFG_IDX_W = 3;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_XX = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHEAR_XY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHEAR_YX = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_YY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y = 3'd5;

    // Identity matrix after reset: 1.0 in Q16.16 on the diagonal.
    localparam logic signed [COORD_W-1:0] RST_SCALE = 32'sd65536;
    localparam logic signed [COORD_W-1:0] RST_ZERO  = 32'sd0;

    typedef struct packed {
        logic signed [COORD_W-1:0] rect_x;
        logic signed [COORD_W-1:0] rect_y;
        logic        [SIZE_W-1:0]  rect_width;
        logic        [SIZE_W-1:0]  rect_height;
    } t_rect;

    typedef struct packed {
        logic signed [COORD_W-1:0] box_x;
        logic signed [COORD_W-1:0] box_y;
        logic        [COORD_W-1:0] box_width;
        logic        [COORD_W-1:0] box_height;
    } t_box;

    // Load enables of the pipeline stages inside each axis unit.
    typedef struct packed {
        logic ld_corner;
        logic ld_prod;
        logic ld_sum;
        logic ld_span;
    } t_stage_ld;

endpackage

`default_nettype wire

>>> src/afbb_minmax.sv
`timescale 1ns / 1ps
`default_nettype none

module afbb_minmax (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_ld,
    input  wire logic signed [afbb_pkg::COORD_W-1:0]    i_c0,
    input  wire logic signed [afbb_pkg::COORD_W-1:0]    i_c1,
    input  wire logic signed [afbb_pkg::COORD_W-1:0]    i_c2,
    input  wire logic signed [afbb_pkg::COORD_W-1:0]    i_c3,
    output logic signed [afbb_pkg::COORD_W-1:0]         o_min,
    output logic signed [afbb_pkg::COORD_W-1:0]         o_max
);

    logic signed [afbb_pkg::COORD_W-1:0] w_lo01, w_lo23, w_hi01, w_hi23;
    logic signed [afbb_pkg::COORD_W-1:0] n_min, n_max, r_min, r_max;

    always_comb begin
        w_lo01 = (i_c1 < i_c0) ? i_c1 : i_c0;
        w_hi01 = (i_c1 > i_c0) ? i_c1 : i_c0;
        w_lo23 = (i_c3 < i_c2) ? i_c3 : i_c2;
        w_hi23 = (i_c3 > i_c2) ? i_c3 : i_c2;
        n_min  = (w_lo23 < w_lo01) ? w_lo23 : w_lo01;
        n_max  = (w_hi23 > w_hi01) ? w_hi23 : w_hi01;
    end

    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_min <= n_min;
            r_max <= n_max;
        end
    end

    assign o_min = r_min;
    assign o_max = r_max;

endmodule

`default_nettype wire

>>> src/afbb_axis.sv
`timescale 1ns / 1ps
`default_nettype none

// One output axis: new = k_p*p + k_q*q + off at the four corners, then min and max.
module afbb_axis (
    input  wire logic                                   i_clk,
    input  wire afbb_pkg::t_stage_ld                    i_ld,
    input  wire logic signed [afbb_pkg::COORD_W-1:0]    i_p0,
    input  wire logic        [afbb_pkg::SIZE_W-1:0]     i_pw,
    input  wire logic signed [afbb_pkg::COORD_W-1:0]    i_q0,
    input  wire logic        [afbb_pkg::SIZE_W-1:0]     i_qh,
    input  wire logic signed [afbb_pkg::COORD_W-1:0]    i_k_p,
    input  wire logic signed [afbb_pkg::COORD_W-1:0]    i_k_q,
    input  wire logic signed [afbb_pkg::COORD_W-1:0]    i_off,
    output logic signed [afbb_pkg::COORD_W-1:0]         o_min,
    output logic signed [afbb_pkg::COORD_W-1:0]         o_max
);

    localparam int PT_W   = afbb_pkg::COORD_W + 1;
    localparam int MUL_W  = afbb_pkg::COORD_W + PT_W;
    localparam int FLR_W  = MUL_W - 16;
    localparam int SUM_W  = FLR_W + 1;
    localparam int CW     = afbb_pkg::COORD_W;

    // Floored products plus offset, clamped to the signed 32-bit range.
    function automatic logic signed [CW-1:0] sat_sum(
        input logic signed [FLR_W-1:0] a,
        input logic signed [FLR_W-1:0] b,
        input logic signed [CW-1:0]    off
    );
        logic signed [SUM_W-1:0] s;
        logic signed [CW-1:0]    res;
        s = SUM_W'(a) + SUM_W'(b) + SUM_W'(off);
        if (s[SUM_W-1:CW-1] == {(SUM_W-CW+1){1'b0}} ||
            s[SUM_W-1:CW-1] == {(SUM_W-CW+1){1'b1}}) begin
            res = s[CW-1:0];
        end else if (s[SUM_W-1]) begin
            res = {1'b1, {(CW-1){1'b0}}};
        end else begin
            res = {1'b0, {(CW-1){1'b1}}};
        end
        return res;
    endfunction

    logic signed [PT_W-1:0]  r_p0, r_p1, r_q0, r_q1;
    logic signed [MUL_W-1:0] w_mp0, w_mp1, w_mq0, w_mq1;
    logic signed [FLR_W-1:0] r_mp0, r_mp1, r_mq0, r_mq1;
    logic signed [CW-1:0]    r_c0, r_c1, r_c2, r_c3;

    // Far corners are formed exactly at 33 bits.
    always_ff @(posedge i_clk) begin
        if (i_ld.ld_corner) begin
            r_p0 <= PT_W'(i_p0);
            r_p1 <= PT_W'(i_p0) + $signed({2'b00, i_pw});
            r_q0 <= PT_W'(i_q0);
            r_q1 <= PT_W'(i_q0) + $signed({2'b00, i_qh});
        end
    end

    assign w_mp0 = i_k_p * r_p0;
    assign w_mp1 = i_k_p * r_p1;
    assign w_mq0 = i_k_q * r_q0;
    assign w_mq1 = i_k_q * r_q1;

    // Dropping the low 16 bits of a two's complement product floors it.
    always_ff @(posedge i_clk) begin
        if (i_ld.ld_prod) begin
            r_mp0 <= w_mp0[MUL_W-1:16];
            r_mp1 <= w_mp1[MUL_W-1:16];
            r_mq0 <= w_mq0[MUL_W-1:16];
            r_mq1 <= w_mq1[MUL_W-1:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld.ld_sum) begin
            r_c0 <= sat_sum(r_mp0, r_mq0, i_off);
            r_c1 <= sat_sum(r_mp1, r_mq0, i_off);
            r_c2 <= sat_sum(r_mp0, r_mq1, i_off);
            r_c3 <= sat_sum(r_mp1, r_mq1, i_off);
        end
    end

    afbb_minmax u_minmax (
        .i_clk (i_clk),
        .i_ld  (i_ld.ld_span),
        .i_c0  (r_c0),
        .i_c1  (r_c1),
        .i_c2  (r_c2),
        .i_c3  (r_c3),
        .o_min (o_min),
        .o_max (o_max)
    );

endmodule

`default_nettype wire

>>> src/affine_rect_bounding_box.sv
// The edge that accepts a word loads the corners; the products, sums, min/max and
// output register then load in that order, each when the stage after it has room.
// Throughput: one word per cycle while the output is not stalled; each 33 by 32 bit
// multiply has a stage to itself.
// Reset (synchronous, active low) empties the pipeline and loads the identity matrix
// with zero offset.
`timescale 1ns / 1ps
`default_nettype none

module affine_rect_bounding_box (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [afbb_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [afbb_pkg::COORD_W-1:0]       i_cfg_data,
    input  wire logic                               i_in_valid,
    input  wire afbb_pkg::t_rect                    i_in_data,
    output logic                                    o_in_stall,
    output logic                                    o_out_valid,
    output afbb_pkg::t_box                          o_out_data,
    input  wire logic                               i_out_stall
);

    localparam int NUM_ST = 4;

    logic signed [afbb_pkg::COORD_W-1:0] r_scale_xx, r_shear_xy, r_shear_yx;
    logic signed [afbb_pkg::COORD_W-1:0] r_scale_yy, r_offset_x, r_offset_y;

    logic [NUM_ST-1:0]   r_v;
    logic                r_out_valid;
    afbb_pkg::t_box      r_out_data, n_out_data;
    logic [NUM_ST:0]     w_rdy;
    afbb_pkg::t_stage_ld w_ld;
    logic                w_in_acc;

    logic signed [afbb_pkg::COORD_W-1:0] w_min_x, w_max_x, w_min_y, w_max_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_xx <= afbb_pkg::RST_SCALE;
            r_shear_xy <= afbb_pkg::RST_ZERO;
            r_shear_yx <= afbb_pkg::RST_ZERO;
            r_scale_yy <= afbb_pkg::RST_SCALE;
            r_offset_x <= afbb_pkg::RST_ZERO;
            r_offset_y <= afbb_pkg::RST_ZERO;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                afbb_pkg::CFG_SCALE_XX: r_scale_xx <= i_cfg_data;
                afbb_pkg::CFG_SHEAR_XY: r_shear_xy <= i_cfg_data;
                afbb_pkg::CFG_SHEAR_YX: r_shear_yx <= i_cfg_data;
                afbb_pkg::CFG_SCALE_YY: r_scale_yy <= i_cfg_data;
                afbb_pkg::CFG_OFFSET_X: r_offset_x <= i_cfg_data;
                afbb_pkg::CFG_OFFSET_Y: r_offset_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A stage may load when it is empty or when the stage after it moves on.
    always_comb begin
        w_rdy[NUM_ST] = !r_out_valid || !i_out_stall;
        for (int k = NUM_ST - 1; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end

    assign w_ld.ld_corner = w_rdy[0];
    assign w_ld.ld_prod   = w_rdy[1];
    assign w_ld.ld_sum    = w_rdy[2];
    assign w_ld.ld_span   = w_rdy[3];

    assign o_in_stall = !w_rdy[0];
    assign w_in_acc   = i_in_valid && w_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_rdy[0]) begin
                r_v[0] <= i_in_valid;
            end
            for (int k = 1; k < NUM_ST; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
            if (w_rdy[NUM_ST]) begin
                r_out_valid <= r_v[NUM_ST-1];
            end
        end
    end

    afbb_axis u_axis_x (
        .i_clk (i_clk),
        .i_ld  (w_ld),
        .i_p0  (i_in_data.rect_x),
        .i_pw  (i_in_data.rect_width),
        .i_q0  (i_in_data.rect_y),
        .i_qh  (i_in_data.rect_height),
        .i_k_p (r_scale_xx),
        .i_k_q (r_shear_yx),
        .i_off (r_offset_x),
        .o_min (w_min_x),
        .o_max (w_max_x)
    );

    afbb_axis u_axis_y (
        .i_clk (i_clk),
        .i_ld  (w_ld),
        .i_p0  (i_in_data.rect_x),
        .i_pw  (i_in_data.rect_width),
        .i_q0  (i_in_data.rect_y),
        .i_qh  (i_in_data.rect_height),
        .i_k_p (r_shear_xy),
        .i_k_q (r_scale_yy),
        .i_off (r_offset_y),
        .o_min (w_min_y),
        .o_max (w_max_y)
    );

    // The clamped corners keep max minus min within 32 unsigned bits.
    always_comb begin
        n_out_data.box_x      = w_min_x;
        n_out_data.box_y      = w_min_y;
        n_out_data.box_width  = $unsigned(w_max_x) - $unsigned(w_min_x);
        n_out_data.box_height = $unsigned(w_max_y) - $unsigned(w_min_y);
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[NUM_ST]) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // The input is held off only when every stage is full and the output is stalled.
    a_stall_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_v == {NUM_ST{1'b1}} && o_out_valid && i_out_stall))
        else $error("input stalled while the pipeline has room");

    // With the output free-running, an accepted word passes the corner, product, sum,
    // min/max and output registers in that order and is then seen on the output.
    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(w_in_acc, 5) && $past(i_rst_n, 5) && $past(i_rst_n, 4) &&
         $past(i_rst_n, 3) && $past(i_rst_n, 2) && $past(i_rst_n, 1) &&
         !$past(i_out_stall, 1) && !$past(i_out_stall, 2) &&
         !$past(i_out_stall, 3) && !$past(i_out_stall, 4)) |-> o_out_valid)
        else $error("accepted word did not reach the output in time");

    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && r_v == {NUM_ST{1'b0}}))
        else $error("pipeline not empty after reset");

endmodule

`default_nettype wire
